FILE: hw/rtl/qpsk_correlator_demodulator_unit_defines.svh
// Assertion macros shared by the RTL of the correlator demodulator.
`ifndef QPSK_CORRELATOR_DEMODULATOR_UNIT_DEFINES_SVH
`define QPSK_CORRELATOR_DEMODULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define QCD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define QCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/qcd_pkg.sv
`default_nettype none

package qcd_pkg;

  // Default widths of the sample fields and the accumulators.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF    = 48;

  // sqrt(2)/2 in Q1.15, and the rounding applied after scaling by it.
  localparam int OFFSET_K    = 23170;
  localparam int K_W         = 16;
  localparam int ROUND_SHIFT = 15;
  localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);

  // Multiplier schedule.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_I_FIRST  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_I_SECOND = 3'd1;
  localparam logic [STEP_W-1:0] STEP_Q_FIRST  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_Q_SECOND = 3'd3;
  localparam logic [STEP_W-1:0] STEP_I_SCALE  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_Q_SCALE  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_SAT,
    ST_DECIDE
  } state_e;

  typedef enum logic [1:0] {
    AM_LOAD,
    AM_ADD,
    AM_SUB,
    AM_ROUND
  } acc_mode_e;

  // What to do with the registered product in the cycle after it is formed.
  typedef struct packed {
    logic      vld;
    logic      to_q;
    acc_mode_e mode;
  } acc_op_t;

endpackage

`default_nettype wire

FILE: hw/rtl/qcd_if.sv
`default_nettype none

// Input channel: one complex sample, one carrier reference and the symbol strobe.
interface qcd_sample_if #(
  parameter int SAMPLE_BITS = qcd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_re;
  logic signed [SAMPLE_BITS-1:0] sample_im;
  logic signed [SAMPLE_BITS-1:0] carrier_re;
  logic signed [SAMPLE_BITS-1:0] carrier_im;
  logic                          symbol_strobe;

  modport source (
    output valid, sample_re, sample_im, carrier_re, carrier_im, symbol_strobe,
    input  ready
  );
  modport sink (
    input  valid, sample_re, sample_im, carrier_re, carrier_im, symbol_strobe,
    output ready
  );
endinterface

// Result channel: one decided bit pair per symbol.
interface qcd_result_if;
  logic valid;
  logic ready;
  logic i_bit;
  logic q_bit;

  modport source (output valid, i_bit, q_bit, input ready);
  modport sink (input valid, i_bit, q_bit, output ready);
endinterface

// Configuration write channel for the single register.
interface qcd_cfg_if;
  logic valid;
  logic ready;
  logic offset_enable;

  modport source (output valid, offset_enable, input ready);
  modport sink (input valid, offset_enable, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/qpsk_correlator_demodulator_unit.sv
`default_nettype none
`include "qpsk_correlator_demodulator_unit_defines.svh"

// QPSK coherent correlation demodulator. Each transfer on sample_i carries one
// complex received sample, one complex carrier reference and a symbol strobe.
// The sample is correlated against the conjugated reference (optionally rotated
// by 45 degrees when offset_enable is set) in phase and in quadrature, and both
// correlations are added into symmetric saturating accumulators. On a strobe the
// largest of I, Q, -I, -Q (ties to the earlier one) is mapped to the bit pair
// 11, 01, 00, 10 and transferred on result_o, and the accumulators clear.
// Timing: all products go through one shared multiplier with a registered
// output, one product per cycle. After its transfer a sample runs through
// 4 products, a drain state and the accumulate state, and the block then
// returns to idle, where it takes the next transfer; it takes no new sample
// before then. With offset_enable set, 2 more products do the sqrt(2)/2
// scaling, and on a strobe a decision state follows the accumulate state.
// The result sits in an output register, so the next sample is taken while it
// waits; only a second decision stalls until the first result has been
// transferred.
// offset_enable may only be written while the block is idle.
module qpsk_correlator_demodulator_unit #(
  parameter int SAMPLE_BITS = qcd_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = qcd_pkg::ACC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  qcd_cfg_if.sink       cfg_i,
  qcd_sample_if.sink    sample_i,
  qcd_result_if.source  result_o
);
  import qcd_pkg::*;

  // Operand widths: the sum and difference of the carrier parts need one more
  // bit, and the scaling constant needs K_W bits.
  localparam int OP_W  = SAMPLE_BITS + 1;
  localparam int B_W   = (OP_W > K_W) ? OP_W : K_W;
  // A raw correlation is the sum of two products of SAMPLE_BITS x OP_W bits.
  localparam int RAW_W = 2 * SAMPLE_BITS + 2;
  localparam int P_W   = RAW_W + B_W;
  localparam int SUM_W = ((ACC_BITS > RAW_W) ? ACC_BITS : RAW_W) + 1;
  localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS - 1){1'b0}}};

  // Saturating add to +-(2^(ACC_BITS-1) - 1). The sum is formed one bit wider
  // than either operand, so the compare against the limits is exact.
  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] acc,
    input logic signed [RAW_W-1:0]    corr
  );
    logic signed [SUM_W-1:0] total;
    logic signed [SUM_W-1:0] lim;
    logic signed [SUM_W-1:0] neg_lim;
    total   = SUM_W'(acc) + SUM_W'(corr);
    lim     = SUM_W'({1'b0, {(ACC_BITS - 1){1'b1}}});
    neg_lim = -lim;
    if (total > lim) begin
      return lim[ACC_BITS-1:0];
    end else if (total < neg_lim) begin
      return neg_lim[ACC_BITS-1:0];
    end
    return total[ACC_BITS-1:0];
  endfunction

  // Control state.
  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [STEP_W-1:0]   last_step;
  acc_op_t             pend_q, pend_d;
  logic                offset_q;
  logic                out_valid_q;

  // Captured sample and reference.
  logic signed [SAMPLE_BITS-1:0] xr_q, xi_q, cr_q, ci_q;
  logic signed [OP_W-1:0]        cdiff_q, csum_q;
  logic                          strobe_q;

  // Shared multiplier and the correlation registers it feeds.
  logic signed [RAW_W-1:0] mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [P_W-1:0]   prod_q;
  logic signed [P_W-1:0]   prod_rnd;
  logic signed [RAW_W-1:0] prod_upd;
  logic signed [RAW_W-1:0] corr_tgt;
  logic signed [RAW_W-1:0] corr_new;
  logic signed [RAW_W-1:0] corr_i_q, corr_q_q;
  acc_op_t                 step_op;

  // Accumulators and the decision.
  logic signed [ACC_BITS-1:0] acc_i_q, acc_q_q;
  logic [ACC_BITS-1:0]        abs_i, abs_q;
  logic                       i_ge_q, q_ge_i;
  logic                       dec_i, dec_q;
  logic                       out_i_q, out_q_q;

  // FSM outputs.
  logic in_take;
  logic mul_en;
  logic sat_en;
  logic out_free;
  logic dec_en;

  assign cfg_i.ready     = 1'b1;
  assign sample_i.ready  = (state_q == ST_IDLE);
  assign result_o.valid  = out_valid_q;
  assign result_o.i_bit  = out_i_q;
  assign result_o.q_bit  = out_q_q;

  assign in_take   = sample_i.valid && sample_i.ready;
  assign out_free  = !out_valid_q || result_o.ready;
  assign last_step = offset_q ? STEP_Q_SCALE : STEP_Q_SECOND;

  // Operand selection for the current step. Without the offset rotation the
  // correlations are xr*cr + xi*ci and xi*cr - xr*ci. With it the carrier sum
  // and difference take the place of the carrier parts, and two more steps
  // scale both raw sums by sqrt(2)/2 with rounding half up.
  always_comb begin
    mul_a   = RAW_W'(xr_q);
    mul_b   = B_W'(cr_q);
    step_op = '{vld: 1'b1, to_q: 1'b0, mode: AM_LOAD};
    unique case (step_q)
      STEP_I_FIRST: begin
        mul_a   = RAW_W'(xr_q);
        mul_b   = offset_q ? B_W'(cdiff_q) : B_W'(cr_q);
        step_op = '{vld: 1'b1, to_q: 1'b0, mode: AM_LOAD};
      end
      STEP_I_SECOND: begin
        mul_a   = RAW_W'(xi_q);
        mul_b   = offset_q ? B_W'(csum_q) : B_W'(ci_q);
        step_op = '{vld: 1'b1, to_q: 1'b0, mode: AM_ADD};
      end
      STEP_Q_FIRST: begin
        mul_a   = RAW_W'(xi_q);
        mul_b   = offset_q ? B_W'(cdiff_q) : B_W'(cr_q);
        step_op = '{vld: 1'b1, to_q: 1'b1, mode: AM_LOAD};
      end
      STEP_Q_SECOND: begin
        mul_a   = RAW_W'(xr_q);
        mul_b   = offset_q ? B_W'(csum_q) : B_W'(ci_q);
        step_op = '{vld: 1'b1, to_q: 1'b1, mode: AM_SUB};
      end
      STEP_I_SCALE: begin
        mul_a   = corr_i_q;
        mul_b   = B_W'(OFFSET_K);
        step_op = '{vld: 1'b1, to_q: 1'b0, mode: AM_ROUND};
      end
      default: begin
        mul_a   = corr_q_q;
        mul_b   = B_W'(OFFSET_K);
        step_op = '{vld: 1'b1, to_q: 1'b1, mode: AM_ROUND};
      end
    endcase
  end

  // Apply the registered product of the previous step to its correlation.
  assign prod_rnd = (prod_q + P_W'(ROUND_HALF)) >>> ROUND_SHIFT;
  assign prod_upd = (pend_q.mode == AM_ROUND) ? prod_rnd[RAW_W-1:0] : prod_q[RAW_W-1:0];
  assign corr_tgt = pend_q.to_q ? corr_q_q : corr_i_q;

  always_comb begin
    case (pend_q.mode)
      AM_ADD:  corr_new = corr_tgt + prod_upd;
      AM_SUB:  corr_new = corr_tgt - prod_upd;
      default: corr_new = prod_upd;
    endcase
  end

  // Decision. The accumulators never hold the most negative value, so the
  // magnitudes do not overflow. Candidates are checked in the order I, Q, -I,
  // -Q so that a tie goes to the earlier one.
  assign abs_i  = acc_i_q[ACC_BITS-1] ? -acc_i_q : acc_i_q;
  assign abs_q  = acc_q_q[ACC_BITS-1] ? -acc_q_q : acc_q_q;
  assign i_ge_q = (abs_i >= abs_q);
  assign q_ge_i = (abs_q >= abs_i);

  always_comb begin
    if (!acc_i_q[ACC_BITS-1] && i_ge_q) begin
      dec_i = 1'b1;
      dec_q = 1'b1;
    end else if (!acc_q_q[ACC_BITS-1] && q_ge_i) begin
      dec_i = 1'b0;
      dec_q = 1'b1;
    end else if (i_ge_q) begin
      dec_i = 1'b0;
      dec_q = 1'b0;
    end else begin
      dec_i = 1'b1;
      dec_q = 1'b0;
    end
  end

  // Sequencer: next state and strobes.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    pend_d  = '{vld: 1'b0, to_q: 1'b0, mode: AM_LOAD};
    mul_en  = 1'b0;
    sat_en  = 1'b0;
    dec_en  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          step_d  = STEP_I_FIRST;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_en = 1'b1;
        pend_d = step_op;
        if (step_q == last_step) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_SAT;
      end
      ST_SAT: begin
        sat_en  = 1'b1;
        state_d = strobe_q ? ST_DECIDE : ST_IDLE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          dec_en  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_I_FIRST;
      pend_q  <= '{vld: 1'b0, to_q: 1'b0, mode: AM_LOAD};
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pend_q  <= pend_d;
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      offset_q <= cfg_i.offset_enable;
    end
  end

  // Accumulators and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_i_q     <= '0;
      acc_q_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (sat_en) begin
        acc_i_q <= sat_add(acc_i_q, corr_i_q);
        acc_q_q <= sat_add(acc_q_q, corr_q_q);
      end else if (dec_en) begin
        acc_i_q <= '0;
        acc_q_q <= '0;
      end
      if (dec_en) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      xr_q     <= sample_i.sample_re;
      xi_q     <= sample_i.sample_im;
      cr_q     <= sample_i.carrier_re;
      ci_q     <= sample_i.carrier_im;
      cdiff_q  <= OP_W'(sample_i.carrier_re) - OP_W'(sample_i.carrier_im);
      csum_q   <= OP_W'(sample_i.carrier_re) + OP_W'(sample_i.carrier_im);
      strobe_q <= sample_i.symbol_strobe;
    end
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (pend_q.vld) begin
      if (pend_q.to_q) begin
        corr_q_q <= corr_new;
      end else begin
        corr_i_q <= corr_new;
      end
    end
    if (dec_en) begin
      out_i_q <= dec_i;
      out_q_q <= dec_q;
    end
  end

  // A transferred sample always starts the multiplier schedule from its first step.
  `QCD_ASSERT_NEXT(a_take_starts_mul, clk_i, rst_ni, in_take,
                   (state_q == ST_MUL) && (step_q == STEP_I_FIRST),
                   "sample transfer did not start the multiplier schedule")
  // The step counter never runs past the last product of the current mode.
  `QCD_ASSERT_IMPLIES(a_step_bound, clk_i, rst_ni, state_q == ST_MUL,
                      step_q <= last_step, "multiplier step past the schedule end")
  // Symmetric saturation keeps both accumulators off the most negative value.
  `QCD_ASSERT_IMPLIES(a_acc_sym, clk_i, rst_ni, 1'b1,
                      (acc_i_q != ACC_MIN) && (acc_q_q != ACC_MIN),
                      "accumulator reached the most negative value")
  // A decision presents a result and leaves both accumulators cleared.
  `QCD_ASSERT_NEXT(a_decide_clears, clk_i, rst_ni, dec_en,
                   out_valid_q && (acc_i_q == '0) && (acc_q_q == '0),
                   "decision did not load the result and clear the sums")

endmodule

`default_nettype wire
